[sv/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescape unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Default depth of the job queue between the front and back parts.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_NO_QUOTE = 2'd1;
  localparam logic [1:0] ERR_BAD_HEX  = 2'd2;
  localparam logic [1:0] ERR_UNTERM   = 2'd3;

  // One job holds every result caused by one input byte: up to three data
  // bytes followed by an optional close or error result.
  typedef struct packed {
    logic [1:0]      n_data;
    logic [2:0][7:0] data;
    logic            has_tail;
    logic [1:0]      tail_kind;
    logic [1:0]      tail_err;
  } jsu_job_t;

endpackage

[sv/json_string_unescape_unit.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_unit
// Streaming unescaper for quoted JSON string literals, one byte per cycle while in_tready is high.
// ----------------------------------------------------------------------------
// Path: a byte's results pass through the job queue and the output register.
// Throughput: one byte per cycle while the job queue has room; a closing \u
// digit yields up to three data bytes (four results with an unterminated
// error), which the job queue absorbs while the output stage drains one
// result per cycle while out_tready is high.
// Reset: synchronous active-low rst_n clears the parse state, the queue and
// the output stage; the unit then waits for an opening quote.
// ----------------------------------------------------------------------------
module json_string_unescape_unit
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [3:0] out_tuser,  // [1:0] kind, [3:2] err_code
  output logic       out_tlast   // last
);

  jsu_job_t   push_job;
  jsu_job_t   head_job;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_not_empty;
  logic [1:0] kind;
  logic [1:0] err;

  // Front: accept and classify source bytes.
  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_final (in_tlast),
    .q_full   (q_full),
    .in_ready (in_tready),
    .push     (push),
    .job      (push_job)
  );

  // Job queue between the two parts.
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // Back: emit the results of each job in order.
  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_not_empty),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_kind   (kind),
    .out_err    (err),
    .out_last   (out_tlast)
  );

  assign out_tuser = {err, kind};

endmodule

[sv/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front
// Accepts source bytes, tracks the literal parse state and turns each byte
// that has results into one job describing all of them.
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic [7:0] in_byte,
  input  logic     in_final,
  input  logic     q_full,
  output logic     in_ready,
  output logic     push,
  output jsu_job_t job
);

  // Parse states.
  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_BODY = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [11:0] cp_r, cp_nxt;

  logic        accept;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp_full;
  logic        done;
  logic [1:0]  mode_step;

  // Map a single-letter escape to its control byte; any other letter maps to itself.
  function automatic logic [7:0] map_escape(input logic [7:0] e);
    logic [7:0] r;
    unique case (e)
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = e;
    endcase
    return r;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Hex digit decode, either letter case.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_full = {cp_r, hex_val};

  // Per-byte classification and job construction.
  always_comb begin
    mode_step   = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    cp_nxt      = cp_r;
    done        = 1'b0;
    job         = '0;
    unique case (mode_r)
      MODE_WAIT: begin
        if (in_byte == CH_QUOTE) begin
          mode_step = MODE_BODY;
        end else begin
          job.has_tail  = 1'b1;
          job.tail_kind = KIND_ERROR;
          job.tail_err  = ERR_NO_QUOTE;
          done          = 1'b1;
        end
      end
      MODE_BODY: begin
        if (in_byte == CH_QUOTE) begin
          job.has_tail  = 1'b1;
          job.tail_kind = KIND_CLOSE;
          done          = 1'b1;
        end else if (in_byte == CH_BSLASH) begin
          mode_step = MODE_ESC;
        end else begin
          job.n_data  = 2'd1;
          job.data[0] = in_byte;
        end
      end
      MODE_ESC: begin
        if (in_byte == CH_U) begin
          mode_step   = MODE_HEX;
          hex_cnt_nxt = 2'd0;
          cp_nxt      = '0;
        end else begin
          job.n_data  = 2'd1;
          job.data[0] = map_escape(in_byte);
          mode_step   = MODE_BODY;
        end
      end
      MODE_HEX: begin
        if (!hex_ok) begin
          job.has_tail  = 1'b1;
          job.tail_kind = KIND_ERROR;
          job.tail_err  = ERR_BAD_HEX;
          done          = 1'b1;
        end else if (hex_cnt_r == 2'd3) begin
          // Last digit: encode the code point as UTF-8.
          if (cp_full < 16'h0080) begin
            job.n_data  = 2'd1;
            job.data[0] = cp_full[7:0];
          end else if (cp_full < 16'h0800) begin
            job.n_data  = 2'd2;
            job.data[0] = 8'hC0 | {3'b000, cp_full[10:6]};
            job.data[1] = 8'h80 | {2'b00, cp_full[5:0]};
          end else begin
            job.n_data  = 2'd3;
            job.data[0] = 8'hE0 | {4'h0, cp_full[15:12]};
            job.data[1] = 8'h80 | {2'b00, cp_full[11:6]};
            job.data[2] = 8'h80 | {2'b00, cp_full[5:0]};
          end
          mode_step   = MODE_BODY;
          hex_cnt_nxt = 2'd0;
          cp_nxt      = '0;
        end else begin
          cp_nxt      = cp_full[11:0];
          hex_cnt_nxt = hex_cnt_r + 2'd1;
        end
      end
      default: begin
        mode_step = MODE_WAIT;
      end
    endcase

    // End of source with the literal still open reports unterminated.
    mode_nxt = mode_step;
    if (!done && in_final && mode_step != MODE_WAIT) begin
      job.has_tail  = 1'b1;
      job.tail_kind = KIND_ERROR;
      job.tail_err  = ERR_UNTERM;
      done          = 1'b1;
    end
    if (done) begin
      mode_nxt    = MODE_WAIT;
      hex_cnt_nxt = 2'd0;
      cp_nxt      = '0;
    end
  end

  assign push = accept && (job.n_data != 2'd0 || job.has_tail);

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_WAIT;
      hex_cnt_r <= 2'd0;
      cp_r      <= '0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      cp_r      <= cp_nxt;
    end
  end

endmodule

[sv/jsu_queue.sv]
// ----------------------------------------------------------------------------
// jsu_queue
// Small register queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  jsu_job_t push_job,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output jsu_job_t head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsu_job_t             entry_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Pointer and occupancy updates with wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[sv/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back
// Walks the head job into a registered output stage, one result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  jsu_job_t   head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic [1:0] out_err,
  output logic       out_last
);

  logic       valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [1:0] err_r, err_nxt;
  logic       last_r, last_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       load;

  assign total = {1'b0, head_job.n_data} + {2'b00, head_job.has_tail};
  assign load  = head_valid && (!valid_r || out_ready);
  assign pop   = load && last_nxt;

  // Select the result at the current index: data bytes first, then the tail.
  always_comb begin
    if (idx_r < head_job.n_data) begin
      byte_nxt = head_job.data[idx_r];
      kind_nxt = KIND_DATA;
      err_nxt  = ERR_NONE;
    end else begin
      byte_nxt = 8'h00;
      kind_nxt = head_job.tail_kind;
      err_nxt  = head_job.tail_err;
    end
    last_nxt = ({1'b0, idx_r} == total - 3'd1);
    idx_nxt  = last_nxt ? 2'd0 : idx_r + 2'd1;
  end

  // Output valid and job index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= idx_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      kind_r <= kind_nxt;
      err_r  <= err_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_kind  = kind_r;
  assign out_err   = err_r;
  assign out_last  = last_r;

endmodule
